// ----- src/slpc_pkg.sv -----
// ----------------------------------------------------------------------------
// slpc_pkg
// Shared widths, command codes and register indexes of the slew limited
// position controller.
// ----------------------------------------------------------------------------
package slpc_pkg;

	// sample and gain format
	localparam int SAMPLE_BITS    = 12;
	localparam int GAIN_FRAC_BITS = 12;

	// register widths
	localparam int GAIN_W   = 16;
	localparam int TOL_W    = 12;
	localparam int TARGET_W = 12;
	localparam int SPEED_W  = 7;
	localparam int RATE_W   = 7;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 3;

	// command and drive
	localparam int CMD_W     = 2;
	localparam int DRIVE_W   = 8;
	localparam int DRIVE_MAX = 127;
	localparam int DMAG_W    = DRIVE_W - 1;

	// datapath widths
	localparam int POS_W  = (SAMPLE_BITS > TARGET_W) ? SAMPLE_BITS : TARGET_W;
	localparam int ERR_W  = POS_W + 1;
	localparam int PROD_W = ERR_W + GAIN_W + 1;
	localparam int SLEW_W = PROD_W;
	localparam int CALC_W = PROD_W + 1;

	// register reset values
	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(328);
	localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(5);

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK  = 2'd0,
		CMD_START = 2'd1,
		CMD_STOP  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOL    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RATE   = 3'd4;

endpackage

// ----- src/slew_limited_position_controller.sv -----
// ----------------------------------------------------------------------------
// slew_limited_position_controller
// Proportional position loop with a slew limited, upper clamped drive.
// ----------------------------------------------------------------------------
// Takes one tick per cycle while the output side is not stalled and hands
// back one result per tick via the stage 1 and result registers. The first
// stage forms (target - sample) * gain and the settle window test; the second
// stage closes the slew value loop (step toward the product, upper clamp,
// settle, drive saturation) and loads the result register. Back to back
// ticks are supported because the slew value, armed and settled state are
// only read and written in the second stage, one tick per cycle. The input
// side keeps taking ticks while a result waits, until both stages are full.
// Configuration writes take effect at once and are meant for idle periods.

module slew_limited_position_controller (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_we,
	input  logic [slpc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [slpc_pkg::CFG_W-1:0]           cfg_data,
	// tick input
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [slpc_pkg::CMD_W-1:0]           command,
	input  logic [slpc_pkg::SAMPLE_BITS-1:0]     pot_sample,
	input  logic                                 autonomous,
	// result output
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [slpc_pkg::DRIVE_W-1:0]  drive,
	output logic                                 drive_valid,
	output logic                                 settled,
	output logic                                 armed
);

	localparam int CALC_W = slpc_pkg::CALC_W;
	localparam int FRAC   = slpc_pkg::GAIN_FRAC_BITS;

	// configuration registers
	logic [slpc_pkg::GAIN_W-1:0]   gain_q;
	logic [slpc_pkg::TOL_W-1:0]    tol_q;
	logic [slpc_pkg::TARGET_W-1:0] target_q;
	logic [slpc_pkg::SPEED_W-1:0]  speed_q;
	logic [slpc_pkg::RATE_W-1:0]   rate_q;

	// loop state
	logic signed [slpc_pkg::SLEW_W-1:0] slew_q;
	logic                               armed_q;
	logic                               settled_q;

	// stage 1
	logic                               valid_s1;
	slpc_pkg::cmd_t                     cmd_s1;
	logic                               auton_s1;
	logic signed [slpc_pkg::PROD_W-1:0] prod_s1;
	logic                               near_s1;

	// stage 2, the result register
	logic                                valid_s2;
	logic signed [slpc_pkg::DRIVE_W-1:0] drive_s2;
	logic                                dvalid_s2;
	logic                                settled_s2;
	logic                                armed_s2;

	// handshake
	logic adv_s2;
	logic take_s1;

	// stage 1 datapath
	logic signed [slpc_pkg::ERR_W-1:0]  err_c;
	logic signed [slpc_pkg::GAIN_W:0]   gain_c;
	logic signed [slpc_pkg::PROD_W-1:0] prod_c;
	logic signed [CALC_W-1:0]           prod_x;
	logic signed [CALC_W-1:0]           tol_c;
	logic                               near_c;

	// stage 2 datapath
	logic signed [CALC_W-1:0]            slew_x;
	logic signed [CALC_W-1:0]            rate_x;
	logic signed [CALC_W-1:0]            speed_x;
	logic signed [CALC_W-1:0]            out_x;
	logic signed [CALC_W-1:0]            up_c;
	logic signed [CALC_W-1:0]            dn_c;
	logic signed [CALC_W-1:0]            step_c;
	logic signed [CALC_W-1:0]            clamp_c;
	logic        [CALC_W-1:0]            mag_c;
	logic        [CALC_W-1:0]            mag_sh;
	logic        [slpc_pkg::DMAG_W-1:0]  dmag_c;
	logic signed [slpc_pkg::DRIVE_W-1:0] drive_c;
	logic signed [slpc_pkg::SLEW_W-1:0]  slew_n;
	logic                                armed_n;
	logic                                settled_n;
	logic                                dvalid_n;
	logic signed [slpc_pkg::DRIVE_W-1:0] drive_n;

	// a stage moves when the stage behind it can take its content
	assign adv_s2   = !valid_s2 || out_ready;
	assign take_s1  = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;

	// ------------------------------------------------------------------
	// configuration writes, unknown indexes are dropped
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= slpc_pkg::GAIN_RESET;
			tol_q    <= slpc_pkg::TOL_RESET;
			target_q <= '0;
			speed_q  <= '0;
			rate_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				slpc_pkg::REG_GAIN:   gain_q   <= cfg_data[slpc_pkg::GAIN_W-1:0];
				slpc_pkg::REG_TOL:    tol_q    <= cfg_data[slpc_pkg::TOL_W-1:0];
				slpc_pkg::REG_TARGET: target_q <= cfg_data[slpc_pkg::TARGET_W-1:0];
				slpc_pkg::REG_SPEED:  speed_q  <= cfg_data[slpc_pkg::SPEED_W-1:0];
				slpc_pkg::REG_RATE:   rate_q   <= cfg_data[slpc_pkg::RATE_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// stage 1: position error times gain, settle window test
	// ------------------------------------------------------------------
	always_comb begin
		err_c  = $signed({1'b0, slpc_pkg::POS_W'(target_q)})
		       - $signed({1'b0, slpc_pkg::POS_W'(pot_sample)});
		gain_c = $signed({1'b0, gain_q});
		prod_c = err_c * gain_c;
		prod_x = CALC_W'(prod_c);
		// tolerance is an integer drive magnitude, align it to the product
		tol_c  = $signed(CALC_W'(tol_q) << FRAC);
		// open window: a zero tolerance never settles
		near_c = (prod_x > -tol_c) && (prod_x < tol_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1   <= slpc_pkg::cmd_t'(command);
			auton_s1 <= autonomous;
			prod_s1  <= prod_c;
			near_s1  <= near_c;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: slew step, upper clamp, settle and drive
	// ------------------------------------------------------------------
	always_comb begin
		slew_x  = CALC_W'(slew_q);
		rate_x  = $signed(CALC_W'(rate_q) << FRAC);
		speed_x = $signed(CALC_W'(speed_q) << FRAC);
		out_x   = CALC_W'(prod_s1);
		up_c    = slew_x + rate_x;
		dn_c    = slew_x - rate_x;

		// move toward the product by at most the slew rate, hold on zero
		if (out_x > 0) begin
			step_c = (out_x > up_c) ? up_c : out_x;
		end else if (out_x < 0) begin
			step_c = (out_x < dn_c) ? dn_c : out_x;
		end else begin
			step_c = slew_x;
		end

		// upper clamp only, negative values are bounded by the saturation below
		clamp_c = (step_c > speed_x) ? speed_x : step_c;

		// truncate toward zero, then saturate the magnitude
		mag_c  = clamp_c[CALC_W-1] ? (CALC_W'(0) - clamp_c) : clamp_c;
		mag_sh = mag_c >> FRAC;
		dmag_c = (mag_sh > CALC_W'(slpc_pkg::DRIVE_MAX))
		       ? slpc_pkg::DMAG_W'(slpc_pkg::DRIVE_MAX) : mag_sh[slpc_pkg::DMAG_W-1:0];
		drive_c = clamp_c[CALC_W-1] ? -$signed({1'b0, dmag_c}) : $signed({1'b0, dmag_c});

		// default: state held, status only
		slew_n    = slew_q;
		armed_n   = armed_q;
		settled_n = settled_q;
		dvalid_n  = 1'b0;
		drive_n   = '0;

		case (cmd_s1)
			slpc_pkg::CMD_START: begin
				armed_n   = 1'b1;
				settled_n = 1'b0;
			end
			slpc_pkg::CMD_STOP: begin
				slew_n  = '0;
				armed_n = 1'b0;
			end
			slpc_pkg::CMD_TICK: begin
				if (auton_s1 && armed_q) begin
					if (near_s1) begin
						settled_n = 1'b1;
						slew_n    = '0;
						armed_n   = 1'b0;
					end else begin
						slew_n   = clamp_c[slpc_pkg::SLEW_W-1:0];
						dvalid_n = 1'b1;
						drive_n  = drive_c;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			slew_q    <= '0;
			armed_q   <= 1'b0;
			settled_q <= 1'b1;
		end else begin
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (take_s1) begin
				slew_q    <= slew_n;
				armed_q   <= armed_n;
				settled_q <= settled_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			drive_s2   <= drive_n;
			dvalid_s2  <= dvalid_n;
			settled_s2 <= settled_n;
			armed_s2   <= armed_n;
		end
	end

	assign out_valid   = valid_s2;
	assign drive       = drive_s2;
	assign drive_valid = dvalid_s2;
	assign settled     = settled_s2;
	assign armed       = armed_s2;

endmodule

// ----- src/slpc_checker.sv -----
// ----------------------------------------------------------------------------
// slpc_checker
// Port level checks of the slew limited position controller.
// ----------------------------------------------------------------------------
module slpc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [slpc_pkg::DRIVE_W-1:0] drive,
	input logic                                drive_valid,
	input logic                                settled,
	input logic                                armed
);

	// no drive issued means a zero drive value
	a_idle_drive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !drive_valid |-> drive == '0)
		else $error("drive nonzero without drive_valid");

	// an issued drive comes from an armed, unsettled move
	a_drive_armed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_valid |-> armed && !settled)
		else $error("drive issued outside an active move");

	// an armed move is never marked settled
	a_armed_not_settled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(armed && settled))
		else $error("armed and settled together");

	// saturation is symmetric, the most negative code never appears
	a_drive_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> drive != -$signed(slpc_pkg::DRIVE_W'(slpc_pkg::DRIVE_MAX + 1)))
		else $error("drive outside saturation range");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(drive_valid)
		&& $stable(settled) && $stable(armed))
		else $error("result changed while stalled");

endmodule

bind slew_limited_position_controller slpc_checker u_slpc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.drive       (drive),
	.drive_valid (drive_valid),
	.settled     (settled),
	.armed       (armed)
);

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the slew limited position controller: a directed
// run of status, extreme and settle cases, then random move sequences under
// changing register settings. Each result is checked against a hand-written
// value or an in-bench loop model, with random idling on both handshakes.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_TICKS = 400;
	localparam int DRAIN_CYCLES = 8;

	// one result of the loop, field for field as the ports show it
	typedef struct packed {
		logic signed [slpc_pkg::DRIVE_W-1:0] drive;
		logic                                drive_valid;
		logic                                settled;
		logic                                armed;
	} loop_result_t;

	typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

	// one row of the directed plan: a register write or a tick
	typedef struct packed {
		row_kind_t                        kind;
		logic [slpc_pkg::CFG_IDX_W-1:0]   idx;
		logic [slpc_pkg::CFG_W-1:0]       data;
		slpc_pkg::cmd_t                   cmd;
		logic [slpc_pkg::SAMPLE_BITS-1:0] sample;
		logic                             auton;
		logic                             typed;
		loop_result_t                     want;
	} plan_row_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_we = 1'b0;
	logic [slpc_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
	logic [slpc_pkg::CFG_W-1:0]          cfg_data = '0;
	logic                                in_valid = 1'b0;
	logic                                in_ready;
	logic [slpc_pkg::CMD_W-1:0]          command = slpc_pkg::CMD_TICK;
	logic [slpc_pkg::SAMPLE_BITS-1:0]    pot_sample = '0;
	logic                                autonomous = 1'b0;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic signed [slpc_pkg::DRIVE_W-1:0] drive;
	logic                                drive_valid;
	logic                                settled;
	logic                                armed;

	// no idling on either side while set
	logic steady = 1'b0;

	int cycle_count = 0;
	int mismatch_count = 0;
	int ticks_sent = 0;

	// results still owed by the block, oldest first
	loop_result_t pending_drive_q[$];
	plan_row_t    plan_q[$];

	// mirror of the registers
	logic [slpc_pkg::GAIN_W-1:0]   gain_m = slpc_pkg::GAIN_RESET;
	logic [slpc_pkg::TOL_W-1:0]    tol_m = slpc_pkg::TOL_RESET;
	logic [slpc_pkg::TARGET_W-1:0] target_m = '0;
	logic [slpc_pkg::SPEED_W-1:0]  speed_m = '0;
	logic [slpc_pkg::RATE_W-1:0]   rate_m = '0;

	// mirror of the loop state
	longint slew_m = 0;
	logic   armed_m = 1'b0;
	logic   settled_m = 1'b1;

	slew_limited_position_controller uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.pot_sample  (pot_sample),
		.autonomous  (autonomous),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.drive       (drive),
		.drive_valid (drive_valid),
		.settled     (settled),
		.armed       (armed)
	);

	// 2 ns clock
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[slew_limited_position_controller] ERROR");
			$finish;
		end
	end

	// position loop model: advances the mirrored state by one tick
	function automatic loop_result_t step_position_loop(slpc_pkg::cmd_t cmd,
			logic [slpc_pkg::SAMPLE_BITS-1:0] sample, logic auton);
		loop_result_t r;
		longint err;
		longint prod;
		longint rate;
		longint tol;
		longint ceiling;
		longint mag;
		r = '0;
		if (cmd == slpc_pkg::CMD_START) begin
			// arm only, slew is kept
			armed_m = 1'b1;
			settled_m = 1'b0;
		end else if (cmd == slpc_pkg::CMD_STOP) begin
			slew_m = 0;
			armed_m = 1'b0;
		end else if (cmd == slpc_pkg::CMD_TICK && auton && armed_m) begin
			err = longint'(target_m) - longint'(sample);
			prod = err * longint'(gain_m);
			rate = longint'(rate_m) << slpc_pkg::GAIN_FRAC_BITS;
			tol = longint'(tol_m) << slpc_pkg::GAIN_FRAC_BITS;
			ceiling = longint'(speed_m) << slpc_pkg::GAIN_FRAC_BITS;
			// step toward the product, zero product leaves slew alone
			if (prod > 0) begin
				if (prod > slew_m + rate)
					slew_m = slew_m + rate;
				else
					slew_m = prod;
			end else if (prod < 0) begin
				if (prod < slew_m - rate)
					slew_m = slew_m - rate;
				else
					slew_m = prod;
			end
			// upper clamp only
			if (slew_m > ceiling)
				slew_m = ceiling;
			if (prod > -tol && prod < tol) begin
				settled_m = 1'b1;
				slew_m = 0;
				armed_m = 1'b0;
			end else begin
				mag = (slew_m < 0) ? -slew_m : slew_m;
				mag = mag >> slpc_pkg::GAIN_FRAC_BITS;
				if (mag > slpc_pkg::DRIVE_MAX)
					mag = slpc_pkg::DRIVE_MAX;
				r.drive = slpc_pkg::DRIVE_W'((slew_m < 0) ? -mag : mag);
				r.drive_valid = 1'b1;
			end
		end
		r.settled = settled_m;
		r.armed = armed_m;
		return r;
	endfunction

	// result side: random stalls except in the steady stretch
	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 8);
	end

	// result checker
	always @(posedge clk) begin
		loop_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_drive_q.size() == 0) begin
				$error("result transfer with no tick outstanding");
				mismatch_count++;
			end else begin
				want = pending_drive_q.pop_front();
				if (drive !== want.drive) begin
					$error("drive expected %0d got %0d", want.drive, drive);
					mismatch_count++;
				end
				if (drive_valid !== want.drive_valid) begin
					$error("drive_valid expected %0b got %0b", want.drive_valid,
						drive_valid);
					mismatch_count++;
				end
				if (settled !== want.settled) begin
					$error("settled expected %0b got %0b", want.settled, settled);
					mismatch_count++;
				end
				if (armed !== want.armed) begin
					$error("armed expected %0b got %0b", want.armed, armed);
					mismatch_count++;
				end
			end
		end
	end

	// register write, only once every result is back and no tick is offered
	task automatic write_reg(logic [slpc_pkg::CFG_IDX_W-1:0] idx,
			logic [slpc_pkg::CFG_W-1:0] data);
		in_valid <= 1'b0;
		cfg_we <= 1'b0;
		while (pending_drive_q.size() != 0)
			@(negedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			slpc_pkg::REG_GAIN:   gain_m = data[slpc_pkg::GAIN_W-1:0];
			slpc_pkg::REG_TOL:    tol_m = data[slpc_pkg::TOL_W-1:0];
			slpc_pkg::REG_TARGET: target_m = data[slpc_pkg::TARGET_W-1:0];
			slpc_pkg::REG_SPEED:  speed_m = data[slpc_pkg::SPEED_W-1:0];
			slpc_pkg::REG_RATE:   rate_m = data[slpc_pkg::RATE_W-1:0];
			default:    ;
		endcase
	endtask

	// offer one tick and hold it until the transfer; the model runs on transfer
	task automatic put_tick(slpc_pkg::cmd_t cmd, logic [slpc_pkg::SAMPLE_BITS-1:0] sample,
			logic auton, logic typed, loop_result_t want);
		loop_result_t got;
		cfg_we <= 1'b0;
		while (!steady && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		pot_sample <= sample;
		autonomous <= auton;
		do
			@(posedge clk);
		while (!in_ready);
		got = step_position_loop(cmd, sample, auton);
		pending_drive_q.push_back(typed ? want : got);
		if (cmd != slpc_pkg::CMD_NONE)
			ticks_sent++;
	endtask

	function automatic void plan_reg(logic [slpc_pkg::CFG_IDX_W-1:0] idx, int data);
		plan_row_t row;
		row = '0;
		row.kind = ROW_REG;
		row.idx = idx;
		row.data = slpc_pkg::CFG_W'(data);
		plan_q.push_back(row);
	endfunction

	function automatic void plan_tick(slpc_pkg::cmd_t cmd, int sample, logic auton);
		plan_row_t row;
		row = '0;
		row.kind = ROW_TICK;
		row.cmd = cmd;
		row.sample = slpc_pkg::SAMPLE_BITS'(sample);
		row.auton = auton;
		plan_q.push_back(row);
	endfunction

	// tick whose result is written out by hand
	function automatic void plan_tick_known(slpc_pkg::cmd_t cmd, int sample, logic auton,
			int drv, logic dv, logic st, logic ar);
		plan_row_t row;
		row = '0;
		row.kind = ROW_TICK;
		row.cmd = cmd;
		row.sample = slpc_pkg::SAMPLE_BITS'(sample);
		row.auton = auton;
		row.typed = 1'b1;
		row.want.drive = slpc_pkg::DRIVE_W'(drv);
		row.want.drive_valid = dv;
		row.want.settled = st;
		row.want.armed = ar;
		plan_q.push_back(row);
	endfunction

	// sample around the target, clipped to the pot range
	function automatic logic [slpc_pkg::SAMPLE_BITS-1:0] near_target(int spread);
		int off;
		int pos;
		off = int'($urandom_range(2 * spread)) - spread;
		pos = int'(target_m) + off;
		if (pos < 0)
			pos = 0;
		if (pos > 4095)
			pos = 4095;
		return slpc_pkg::SAMPLE_BITS'(pos);
	endfunction

	// random register set, extremes included
	task automatic random_settings();
		int gain;
		int tol;
		int target;
		int speed;
		int rate;
		case ($urandom_range(9))
			0:       gain = 0;
			1:       gain = 65535;
			2:       gain = $urandom_range(65535);
			default: gain = $urandom_range(200, 6000);
		endcase
		case ($urandom_range(9))
			0:       tol = 0;
			1:       tol = 4095;
			2:       tol = $urandom_range(4095);
			default: tol = $urandom_range(1, 40);
		endcase
		case ($urandom_range(5))
			0:       target = 0;
			1:       target = 4095;
			default: target = $urandom_range(4095);
		endcase
		case ($urandom_range(5))
			0:       speed = 0;
			1:       speed = 127;
			default: speed = $urandom_range(127);
		endcase
		case ($urandom_range(5))
			0:       rate = 0;
			1:       rate = 127;
			default: rate = $urandom_range(1, 40);
		endcase
		write_reg(slpc_pkg::REG_GAIN, slpc_pkg::CFG_W'(gain));
		write_reg(slpc_pkg::REG_TOL, slpc_pkg::CFG_W'(tol));
		write_reg(slpc_pkg::REG_TARGET, slpc_pkg::CFG_W'(target));
		write_reg(slpc_pkg::REG_SPEED, slpc_pkg::CFG_W'(speed));
		write_reg(slpc_pkg::REG_RATE, slpc_pkg::CFG_W'(rate));
	endtask

	// start, a run of ticks closing in on the target, sometimes a stop
	task automatic random_move();
		int spread;
		int len;
		int k;
		int pick;
		put_tick(slpc_pkg::CMD_START, slpc_pkg::SAMPLE_BITS'($urandom), 1'($urandom),
			1'b0, '0);
		spread = $urandom_range(1, 120);
		len = $urandom_range(4, 24);
		k = 0;
		while (k < len && armed_m) begin
			pick = $urandom_range(99);
			if (pick < 4)
				put_tick(slpc_pkg::CMD_STOP, slpc_pkg::SAMPLE_BITS'($urandom),
					1'($urandom), 1'b0, '0);
			else if (pick < 8)
				put_tick(slpc_pkg::CMD_NONE, slpc_pkg::SAMPLE_BITS'($urandom),
					1'($urandom), 1'b0, '0);
			else if (pick < 11)
				put_tick(slpc_pkg::CMD_START, slpc_pkg::SAMPLE_BITS'($urandom),
					1'($urandom), 1'b0, '0);
			else if (pick < 18)
				put_tick(slpc_pkg::CMD_TICK, slpc_pkg::SAMPLE_BITS'($urandom),
					1'($urandom), 1'b0, '0);
			else
				put_tick(slpc_pkg::CMD_TICK, near_target(spread),
					$urandom_range(99) >= 8, 1'b0, '0);
			spread = (spread * 3) / 4;
			k++;
		end
		if ($urandom_range(3) == 0)
			put_tick(slpc_pkg::CMD_STOP, slpc_pkg::SAMPLE_BITS'($urandom), 1'($urandom),
				1'b0, '0);
	endtask

	initial begin
		plan_row_t row;
		int phase;
		int phase_end;

		// status after reset, unused command code, start without autonomy
		plan_tick_known(slpc_pkg::CMD_TICK, 0, 1'b1, 0, 1'b0, 1'b1, 1'b0);
		plan_tick_known(slpc_pkg::CMD_NONE, 4095, 1'b1, 0, 1'b0, 1'b1, 1'b0);
		plan_tick_known(slpc_pkg::CMD_START, 0, 1'b0, 0, 1'b0, 1'b0, 1'b1);
		plan_tick_known(slpc_pkg::CMD_TICK, 0, 1'b0, 0, 1'b0, 1'b0, 1'b1);
		// on target with default gain: settles at once
		plan_tick_known(slpc_pkg::CMD_TICK, 0, 1'b1, 0, 1'b0, 1'b1, 1'b0);
		// full gain, full speed and rate, zero tolerance
		plan_reg(slpc_pkg::REG_GAIN, 65535);
		plan_reg(slpc_pkg::REG_TOL, 0);
		plan_reg(slpc_pkg::REG_TARGET, 4095);
		plan_reg(slpc_pkg::REG_SPEED, 127);
		plan_reg(slpc_pkg::REG_RATE, 127);
		plan_tick_known(slpc_pkg::CMD_START, 0, 1'b1, 0, 1'b0, 1'b0, 1'b1);
		plan_tick_known(slpc_pkg::CMD_TICK, 0, 1'b1, 127, 1'b1, 1'b0, 1'b1);
		// zero error keeps the slew, zero tolerance never settles
		plan_tick_known(slpc_pkg::CMD_TICK, 4095, 1'b1, 127, 1'b1, 1'b0, 1'b1);
		// largest negative error: slew walks down past the drive limit
		plan_reg(slpc_pkg::REG_TARGET, 0);
		plan_tick_known(slpc_pkg::CMD_TICK, 4095, 1'b1, 0, 1'b1, 1'b0, 1'b1);
		plan_tick_known(slpc_pkg::CMD_TICK, 4095, 1'b1, -127, 1'b1, 1'b0, 1'b1);
		plan_tick_known(slpc_pkg::CMD_TICK, 4095, 1'b1, -127, 1'b1, 1'b0, 1'b1);
		plan_tick_known(slpc_pkg::CMD_STOP, 4095, 1'b1, 0, 1'b0, 1'b0, 1'b0);
		plan_tick_known(slpc_pkg::CMD_TICK, 4095, 1'b1, 0, 1'b0, 1'b0, 1'b0);
		// zero gain with the widest tolerance
		plan_reg(slpc_pkg::REG_GAIN, 0);
		plan_reg(slpc_pkg::REG_TOL, 4095);
		plan_reg(slpc_pkg::REG_SPEED, 0);
		plan_reg(slpc_pkg::REG_RATE, 0);
		plan_tick_known(slpc_pkg::CMD_START, 0, 1'b1, 0, 1'b0, 1'b0, 1'b1);
		plan_tick_known(slpc_pkg::CMD_TICK, 1234, 1'b1, 0, 1'b0, 1'b1, 1'b0);
		// unity gain, approach from both sides until inside the window
		plan_reg(slpc_pkg::REG_GAIN, 4096);
		plan_reg(slpc_pkg::REG_TOL, 5);
		plan_reg(slpc_pkg::REG_TARGET, 2048);
		plan_reg(slpc_pkg::REG_SPEED, 60);
		plan_reg(slpc_pkg::REG_RATE, 10);
		plan_tick(slpc_pkg::CMD_START, 0, 1'b1);
		plan_tick(slpc_pkg::CMD_TICK, 2000, 1'b1);
		plan_tick(slpc_pkg::CMD_TICK, 2000, 1'b1);
		plan_tick(slpc_pkg::CMD_TICK, 2030, 1'b1);
		plan_tick(slpc_pkg::CMD_TICK, 2100, 1'b1);
		plan_tick(slpc_pkg::CMD_TICK, 2100, 1'b1);
		plan_tick(slpc_pkg::CMD_TICK, 2046, 1'b1);
		plan_tick(slpc_pkg::CMD_TICK, 2047, 1'b1);
		plan_tick(slpc_pkg::CMD_STOP, 2047, 1'b1);

		// reset
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed plan
		while (plan_q.size() != 0) begin
			row = plan_q.pop_front();
			if (row.kind == ROW_REG)
				write_reg(row.idx, row.data);
			else
				put_tick(row.cmd, row.sample, row.auton, row.typed, row.want);
		end

		// random phases, a fresh register set each time, one long steady one
		phase = 0;
		while (ticks_sent < RANDOM_TICKS - 30) begin
			random_settings();
			steady <= (phase == 2);
			phase_end = ticks_sent + ((phase == 2) ? 120 : $urandom_range(30, 60));
			while (ticks_sent < phase_end)
				random_move();
			phase++;
		end

		// drain
		in_valid <= 1'b0;
		steady <= 1'b0;
		while (pending_drive_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("[slew_limited_position_controller] OK");
		else
			$display("[slew_limited_position_controller] ERROR");
		$finish;
	end

endmodule
